FILE: design/nptt_pkg.sv
// nptt_pkg: shared types and constants of the port translation table
// depends on nothing; used by every module of the block
package nptt_pkg;

  localparam int unsigned SLOTS  = 2048;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = SLOT_W + 1;

  localparam logic [31:0] RST_PUB_ADDR = 32'd0;
  localparam logic [15:0] RST_TIMEOUT  = 16'd30;
  localparam logic [15:0] RST_BASE     = 16'd10000;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_FREE = 2'd0;
  localparam kind_t KIND_UDP  = 2'd1;
  localparam kind_t KIND_TCP  = 2'd2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PUB_ADDR = 2'd0;
  localparam cfg_idx_t CFG_TIMEOUT  = 2'd1;
  localparam cfg_idx_t CFG_BASE     = 2'd2;

  typedef struct packed {
    logic        action;
    logic [31:0] src_address;
    logic [15:0] src_port;
    logic [31:0] dst_address;
    logic [15:0] dst_port;
    logic        syn_flag;
    logic        rst_flag;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic        accept;
    logic [31:0] new_src_address;
    logic [15:0] new_src_port;
    logic [31:0] new_dst_address;
    logic [15:0] new_dst_port;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] inner_address;
    logic [15:0] inner_port;
    logic [31:0] last_use;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_IN_EVAL, S_SCAN, S_OUT_DEC, S_FREE, S_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic dispatch;
    logic scan_step;
    logic in_eval;
    logic out_dec;
    logic free_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic incoming;
    logic in_range;
    logic scan_done;
    logic need_free;
  } sts_t;

endpackage

FILE: design/nptt_ctrl.sv
// nptt_ctrl: sequencing state machine of the port translation table
// depends on nptt_pkg; drives commands to nptt_dp
module nptt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  nptt_pkg::sts_t sts,
  output nptt_pkg::cmd_t cmd
);

  nptt_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nptt_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      nptt_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = nptt_pkg::S_IDLE;
      end
      nptt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = nptt_pkg::S_DISPATCH;
        end
      end
      nptt_pkg::S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        if (!sts.incoming)     state_nxt = nptt_pkg::S_SCAN;
        else if (sts.in_range) state_nxt = nptt_pkg::S_IN_EVAL;
        else                   state_nxt = nptt_pkg::S_DONE;
      end
      nptt_pkg::S_IN_EVAL: begin
        cmd.in_eval = 1'b1;
        state_nxt   = nptt_pkg::S_DONE;
      end
      nptt_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = nptt_pkg::S_OUT_DEC;
      end
      nptt_pkg::S_OUT_DEC: begin
        cmd.out_dec = 1'b1;
        state_nxt   = sts.need_free ? nptt_pkg::S_FREE : nptt_pkg::S_DONE;
      end
      nptt_pkg::S_FREE: begin
        cmd.free_wr = 1'b1;
        state_nxt   = nptt_pkg::S_DONE;
      end
      nptt_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = nptt_pkg::S_IDLE;
        end
      end
      default: state_nxt = nptt_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load)              out_valid_nxt = 1'b1;
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/nptt_dp.sv
// nptt_dp: slot memory, config registers, scan and result logic
// depends on nptt_pkg; commanded by nptt_ctrl
module nptt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr,
  input  nptt_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]         cfg_data,
  input  nptt_pkg::in_item_t  in_data,
  input  nptt_pkg::cmd_t      cmd,
  output nptt_pkg::sts_t      sts,
  output nptt_pkg::out_item_t out_data
);

  localparam logic [nptt_pkg::SLOT_W-1:0] LAST_IDX = nptt_pkg::SLOT_W'(nptt_pkg::SLOTS - 1);
  localparam logic [nptt_pkg::CNT_W-1:0]  CNT_END  = nptt_pkg::CNT_W'(nptt_pkg::SLOTS);

  logic [31:0] pub_r;
  logic [15:0] tmo_r, base_r;
  nptt_pkg::in_item_t  item_r;
  nptt_pkg::entry_t    mem [nptt_pkg::SLOTS];
  nptt_pkg::entry_t    rd_data_r;
  logic [nptt_pkg::SLOT_W-1:0] rd_idx_r;
  logic                        rd_vld_r;
  logic [nptt_pkg::CNT_W-1:0]  cnt_r;
  logic                        match_found_r, match_exp_r, use_found_r;
  logic [nptt_pkg::SLOT_W-1:0] match_idx_r, use_idx_r;
  nptt_pkg::out_item_t         res_r, out_r;

  nptt_pkg::kind_t want;
  logic expired, hit, usable, incoming, in_range, cnt_live;
  logic [15:0] in_off;
  logic [nptt_pkg::SLOT_W-1:0] in_idx, ra, wa, dec_idx;
  logic we, refresh, alloc, dec_acc, in_ok;
  nptt_pkg::entry_t wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pub_r  <= nptt_pkg::RST_PUB_ADDR;
      tmo_r  <= nptt_pkg::RST_TIMEOUT;
      base_r <= nptt_pkg::RST_BASE;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        nptt_pkg::CFG_PUB_ADDR: pub_r  <= cfg_data;
        nptt_pkg::CFG_TIMEOUT:  tmo_r  <= cfg_data[15:0];
        nptt_pkg::CFG_BASE:     base_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign want     = item_r.action ? nptt_pkg::KIND_TCP : nptt_pkg::KIND_UDP;
  assign expired  = (item_r.now_seconds - rd_data_r.last_use) > {16'd0, tmo_r};
  assign hit      = (rd_data_r.kind == want) &&
                    (rd_data_r.inner_address == item_r.src_address) &&
                    (rd_data_r.inner_port == item_r.src_port);
  assign usable   = (rd_data_r.kind != nptt_pkg::KIND_UDP &&
                     rd_data_r.kind != nptt_pkg::KIND_TCP) ||
                    (rd_data_r.kind == nptt_pkg::KIND_UDP && expired);
  assign incoming = item_r.dst_address == pub_r;
  assign in_off   = item_r.dst_port - base_r;
  assign in_idx   = in_off[nptt_pkg::SLOT_W-1:0];
  assign in_range = in_off < 16'(nptt_pkg::SLOTS);
  assign cnt_live = cnt_r < CNT_END;

  // outgoing decision from the finished scan
  always_comb begin
    refresh = 1'b0;
    alloc   = 1'b0;
    dec_acc = 1'b0;
    dec_idx = match_idx_r;
    if (!item_r.action) begin
      if (match_found_r && !match_exp_r) begin
        refresh = 1'b1;
        dec_acc = 1'b1;
      end else if (use_found_r) begin
        alloc   = 1'b1;
        dec_acc = 1'b1;
        dec_idx = use_idx_r;
      end
    end else begin
      if (match_found_r) begin
        dec_acc = 1'b1;
      end else if (item_r.syn_flag && use_found_r) begin
        alloc   = 1'b1;
        dec_acc = 1'b1;
        dec_idx = use_idx_r;
      end
    end
  end

  assign in_ok = item_r.action ? (rd_data_r.kind == nptt_pkg::KIND_TCP)
                               : (rd_data_r.kind == nptt_pkg::KIND_UDP && !expired);

  // single write port
  always_comb begin
    we = 1'b0;
    wa = cnt_r[nptt_pkg::SLOT_W-1:0];
    wd = '0;
    priority if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.out_dec) begin
      we = refresh || alloc;
      wa = dec_idx;
      wd = '{kind: want, inner_address: item_r.src_address,
             inner_port: item_r.src_port, last_use: item_r.now_seconds};
    end else if (cmd.free_wr) begin
      we = 1'b1;
      wa = match_idx_r;
    end else if (cmd.in_eval) begin
      wa = in_idx;
      if (!item_r.action) begin
        we = in_ok;
        wd = rd_data_r;
        wd.last_use = item_r.now_seconds;
      end else begin
        we = in_ok && item_r.rst_flag;
      end
    end
  end

  assign ra = cmd.dispatch ? in_idx : cnt_r[nptt_pkg::SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step && cnt_live;
      if (cmd.dispatch)                             cnt_r <= '0;
      else if (cmd.clr_wr || (cmd.scan_step && cnt_live)) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[nptt_pkg::SLOT_W-1:0];
    if (cmd.capture) item_r <= in_data;
    if (cmd.dispatch) begin
      match_found_r <= 1'b0;
      use_found_r   <= 1'b0;
      res_r         <= '0;
    end else if (cmd.scan_step && rd_vld_r) begin
      if (hit && !match_found_r) begin
        match_found_r <= 1'b1;
        match_idx_r   <= rd_idx_r;
        match_exp_r   <= expired;
      end
      if (usable && !use_found_r) begin
        use_found_r <= 1'b1;
        use_idx_r   <= rd_idx_r;
      end
    end else if (cmd.out_dec) begin
      if (dec_acc) begin
        res_r <= '{accept: 1'b1, new_src_address: pub_r,
                   new_src_port: base_r + 16'(dec_idx),
                   new_dst_address: item_r.dst_address,
                   new_dst_port: item_r.dst_port};
      end
    end else if (cmd.in_eval) begin
      if (in_ok) begin
        res_r <= '{accept: 1'b1, new_src_address: item_r.src_address,
                   new_src_port: item_r.src_port,
                   new_dst_address: rd_data_r.inner_address,
                   new_dst_port: rd_data_r.inner_port};
      end
    end
    if (cmd.out_load) out_r <= res_r;
  end

  assign sts.clr_last  = cnt_r == CNT_END - 1'b1;
  assign sts.incoming  = incoming;
  assign sts.in_range  = in_range;
  assign sts.scan_done = rd_vld_r && (hit || rd_idx_r == LAST_IDX);
  assign sts.need_free = !item_r.action && match_found_r && match_exp_r &&
                         use_found_r && (use_idx_r != match_idx_r);
  assign out_data      = out_r;

endmodule

FILE: design/nat_port_translation_table.sv
// nat_port_translation_table: top level of the udp/tcp port translation table
// depends on nptt_pkg, nptt_ctrl and nptt_dp
//
//  channel   direction  handshake            payload
//  in_       request    in_valid / in_stall  nptt_pkg::in_item_t
//  out_      result     out_valid/out_stall  nptt_pkg::out_item_t
//  cfg_      write      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// incoming request: dispatch and slot read, then evaluation, skipped outside the pool
// outgoing request: a scan reads slots up to the first match or the last slot (at most
//   2048, one slot a cycle through the one read port), a decision, a free if expired
// after reset a clearing pass frees every slot; in_stall is high meanwhile, config
//   writes are taken at any time
// one result register; the next request is accepted while a result waits
module nat_port_translation_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nptt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nptt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  nptt_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]         cfg_data
);

  nptt_pkg::cmd_t cmd;
  nptt_pkg::sts_t sts;

  // config registers are always writable
  assign cfg_ready = 1'b1;

  nptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  nptt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  // a captured request makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while a request is in flight");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_load && out_valid && out_stall))
    else $error("result register overwritten");

  // the clearing pass keeps the input stalled
  a_clear_stalls: assert property (@(posedge clk)
    cmd.clr_wr |-> in_stall)
    else $error("request taken during clearing pass");

  // freeing an old mapping only follows an outgoing decision
  a_free_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.free_wr |-> $past(cmd.out_dec))
    else $error("stray free write");

endmodule

FILE: bench/nptt_checker.sv
// nptt_checker: follows the request, result and register write channels,
// keeps its own copy of the translation table and compares every result
// depends on nptt_pkg
`timescale 1ns / 1ps
module nptt_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  nptt_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  nptt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  nptt_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  errors,
  output int                  pending
);

  nptt_pkg::kind_t     kind_q [nptt_pkg::SLOTS];
  logic [31:0]         addr_q [nptt_pkg::SLOTS];
  logic [15:0]         port_q [nptt_pkg::SLOTS];
  logic [31:0]         used_q [nptt_pkg::SLOTS];
  logic [31:0]         pub;
  logic [15:0]         tmo;
  logic [15:0]         base;
  nptt_pkg::out_item_t due_q[$];

  function automatic bit stale(int i, logic [31:0] now);
    logic [31:0] age;
    age = now - used_q[i];
    return age > {16'd0, tmo};
  endfunction

  function automatic int find_map(nptt_pkg::kind_t k, logic [31:0] a, logic [15:0] p);
    for (int i = 0; i < nptt_pkg::SLOTS; i++)
      if (kind_q[i] == k && addr_q[i] == a && port_q[i] == p) return i;
    return nptt_pkg::SLOTS;
  endfunction

  // lowest slot that is free or holds an expired udp mapping
  function automatic int take_slot(nptt_pkg::kind_t k, logic [31:0] a, logic [15:0] p,
                                   logic [31:0] now);
    for (int i = 0; i < nptt_pkg::SLOTS; i++) begin
      if ((kind_q[i] != nptt_pkg::KIND_UDP && kind_q[i] != nptt_pkg::KIND_TCP) ||
          (kind_q[i] == nptt_pkg::KIND_UDP && stale(i, now))) begin
        kind_q[i] = k;
        addr_q[i] = a;
        port_q[i] = p;
        used_q[i] = now;
        return i;
      end
    end
    return nptt_pkg::SLOTS;
  endfunction

  function automatic nptt_pkg::out_item_t translate(nptt_pkg::in_item_t p);
    nptt_pkg::out_item_t r;
    int                  i;
    logic [15:0]         idx;
    logic [15:0]         sp;
    r = '0;
    if (p.dst_address != pub) begin
      if (!p.action) begin
        i = find_map(nptt_pkg::KIND_UDP, p.src_address, p.src_port);
        if (i < nptt_pkg::SLOTS && stale(i, p.now_seconds)) begin
          kind_q[i] = nptt_pkg::KIND_FREE;
          i = nptt_pkg::SLOTS;
        end
        if (i < nptt_pkg::SLOTS) used_q[i] = p.now_seconds;
        else i = take_slot(nptt_pkg::KIND_UDP, p.src_address, p.src_port, p.now_seconds);
      end else begin
        i = find_map(nptt_pkg::KIND_TCP, p.src_address, p.src_port);
        if (i >= nptt_pkg::SLOTS) begin
          if (!p.syn_flag) return r;
          i = take_slot(nptt_pkg::KIND_TCP, p.src_address, p.src_port, p.now_seconds);
        end
      end
      if (i >= nptt_pkg::SLOTS) return r;
      sp = base + i[15:0];
      r.accept = 1'b1;
      r.new_src_address = pub;
      r.new_src_port = sp;
      r.new_dst_address = p.dst_address;
      r.new_dst_port = p.dst_port;
      return r;
    end
    idx = p.dst_port - base;
    if (idx >= nptt_pkg::SLOTS) return r;
    if (!p.action) begin
      if (kind_q[idx] != nptt_pkg::KIND_UDP || stale(idx, p.now_seconds)) return r;
      used_q[idx] = p.now_seconds;
    end else if (kind_q[idx] != nptt_pkg::KIND_TCP) begin
      return r;
    end
    r.accept = 1'b1;
    r.new_src_address = p.src_address;
    r.new_src_port = p.src_port;
    r.new_dst_address = addr_q[idx];
    r.new_dst_port = port_q[idx];
    if (p.action && p.rst_flag) kind_q[idx] = nptt_pkg::KIND_FREE;
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    nptt_pkg::out_item_t w;
    if (!rst_n) begin
      for (int i = 0; i < nptt_pkg::SLOTS; i++) kind_q[i] = nptt_pkg::KIND_FREE;
      pub = nptt_pkg::RST_PUB_ADDR;
      tmo = nptt_pkg::RST_TIMEOUT;
      base = nptt_pkg::RST_BASE;
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $display("%0t result with none due: %h", $time, out_data);
          errors <= errors + 1;
        end else begin
          w = due_q.pop_front();
          if (w != out_data) begin
            $display("%0t mismatch expected %h actual %h", $time, w, out_data);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nptt_pkg::CFG_PUB_ADDR: pub = cfg_data;
          nptt_pkg::CFG_TIMEOUT:  tmo = cfg_data[15:0];
          nptt_pkg::CFG_BASE:     base = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) due_q.push_back(translate(in_data));
    end
    pending <= due_q.size();
  end

endmodule

FILE: bench/tb_nat_port_translation_table.sv
// tb_nat_port_translation_table: request stimulus, register writes and verdict
// depends on nptt_pkg, nat_port_translation_table and nptt_checker
`timescale 1ns / 1ps
module tb_nat_port_translation_table;

  localparam int WATCH_LIMIT = 40000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  nptt_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  nptt_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  nptt_pkg::cfg_idx_t  cfg_index = nptt_pkg::CFG_PUB_ADDR;
  logic [31:0]         cfg_data = '0;
  int                  errors;
  int                  pending;

  // idling odds in percent, changed per phase
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet = 0;

  // shadow of the registers for building requests
  logic [31:0] pub_now;
  logic [15:0] base_now;
  logic [15:0] tmo_now;
  logic [31:0] secs;

  // small set of inner hosts so mappings get reused
  logic [31:0] hosts_a [8] = '{32'h0, 32'hFFFFFFFF, 32'h0A000001, 32'h0A000002,
                               32'hC0A80105, 32'hAC100A0A, 32'h7F000001, 32'h55AA55AA};
  logic [15:0] hosts_p [8] = '{16'h0, 16'hFFFF, 16'd80, 16'd443,
                               16'd5353, 16'd40000, 16'd12345, 16'hAAAA};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nat_port_translation_table dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  nptt_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // receiver back-pressure
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one request; payload held until taken, then optional idle gap
  task automatic send(input nptt_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // drain: every result back before a register write
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input nptt_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      nptt_pkg::CFG_PUB_ADDR: pub_now = val;
      nptt_pkg::CFG_TIMEOUT:  tmo_now = val[15:0];
      default:                base_now = val[15:0];
    endcase
  endtask

  task automatic set_regs(input logic [31:0] p, input logic [15:0] t,
                          input logic [15:0] b);
    write_reg(nptt_pkg::CFG_PUB_ADDR, p);
    write_reg(nptt_pkg::CFG_TIMEOUT, {16'd0, t});
    write_reg(nptt_pkg::CFG_BASE, {16'd0, b});
  endtask

  function automatic nptt_pkg::in_item_t mk(logic tcp, logic [31:0] sa, logic [15:0] sp,
                                            logic [31:0] da, logic [15:0] dp, logic syn,
                                            logic rst, logic [31:0] now);
    nptt_pkg::in_item_t r;
    r.action = tcp;
    r.src_address = sa;
    r.src_port = sp;
    r.dst_address = da;
    r.dst_port = dp;
    r.syn_flag = syn;
    r.rst_flag = rst;
    r.now_seconds = now;
    return r;
  endfunction

  // mostly well-formed traffic against a few hosts, some noise
  function automatic nptt_pkg::in_item_t rand_req();
    nptt_pkg::in_item_t r;
    int                 sel;
    int                 h;
    sel = $urandom_range(99);
    h = $urandom_range(7);
    // time mostly creeps, sometimes jumps past the timeout
    if ($urandom_range(19) == 0) secs = secs + {16'd0, tmo_now} + $urandom_range(1, 3);
    else secs = secs + $urandom_range(0, 4);
    r = mk(1'($urandom_range(1)), $urandom, 16'($urandom), $urandom, 16'($urandom),
           1'($urandom_range(1)), 1'($urandom_range(1)), secs);
    if (sel < 55) begin
      // outgoing from a known host
      if ($urandom_range(9) != 0) begin
        r.src_address = hosts_a[h];
        r.src_port = hosts_p[h];
      end
      if (r.dst_address == pub_now) r.dst_address[0] = ~r.dst_address[0];
      if (r.action) r.syn_flag = ($urandom_range(9) < 6);
    end else if (sel < 90) begin
      // incoming to the low slots of the pool
      r.dst_address = pub_now;
      if ($urandom_range(99) < 85) r.dst_port = base_now + 16'($urandom_range(0, 24));
      r.rst_flag = ($urandom_range(3) == 0);
    end else begin
      // noise, time included
      r.now_seconds = $urandom;
      if ($urandom_range(1)) r.dst_address = pub_now;
    end
    return r;
  endfunction

  initial begin
    logic [31:0] pa;
    logic [31:0] ha;
    logic [15:0] hp;
    pub_now = nptt_pkg::RST_PUB_ADDR;
    tmo_now = nptt_pkg::RST_TIMEOUT;
    base_now = nptt_pkg::RST_BASE;
    secs = 32'd100;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reuse, expiry, overwrite, tcp open/close, pool edges
    pa = 32'hCB007107;
    set_regs(pa, 16'd5, 16'd10000);
    ha = hosts_a[2];
    hp = hosts_p[2];
    send(mk(1'b0, hosts_a[0], hosts_p[0], 32'h08080808, 16'd53, 1'b0, 1'b0, 32'd100));
    send(mk(1'b0, hosts_a[0], hosts_p[0], 32'h08080808, 16'd53, 1'b0, 1'b0, 32'd103));
    send(mk(1'b0, 32'h08080808, 16'd53, pa, 16'd10000, 1'b0, 1'b0, 32'd105));
    send(mk(1'b0, 32'h08080808, 16'd53, pa, 16'd10000, 1'b0, 1'b0, 32'd200));
    send(mk(1'b0, hosts_a[1], hosts_p[1], 32'h01020304, 16'd9, 1'b0, 1'b0, 32'd200));
    send(mk(1'b0, hosts_a[0], hosts_p[0], 32'h08080808, 16'd53, 1'b0, 1'b0, 32'd200));
    send(mk(1'b1, ha, hp, 32'h01010101, 16'd80, 1'b0, 1'b0, 32'd201));
    send(mk(1'b1, ha, hp, 32'h01010101, 16'd80, 1'b1, 1'b0, 32'd201));
    send(mk(1'b1, ha, hp, 32'h01010101, 16'd80, 1'b0, 1'b1, 32'd202));
    send(mk(1'b1, 32'h01010101, 16'd80, pa, 16'd10002, 1'b0, 1'b0, 32'd203));
    send(mk(1'b1, 32'h01010101, 16'd80, pa, 16'd10002, 1'b1, 1'b1, 32'd204));
    send(mk(1'b1, 32'h01010101, 16'd80, pa, 16'd10002, 1'b0, 1'b1, 32'd205));
    send(mk(1'b0, 32'h01010101, 16'd80, pa, 16'd9999, 1'b0, 1'b0, 32'd205));
    send(mk(1'b1, 32'h01010101, 16'd80, pa, 16'd12048, 1'b0, 1'b0, 32'd205));
    // matching udp mapping found expired: freed, and the lowest usable slot taken
    send(mk(1'b0, hosts_a[1], hosts_p[1], 32'h01020304, 16'd9, 1'b0, 1'b0, 32'd300));
    send(mk(1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 1'b1, 1'b1, 32'hFFFFFFFF));
    send(mk(1'b1, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 1'b1, 32'h0));
    send(mk(1'b0, 32'hFFFFFFFF, 16'hFFFF, pa, 16'hFFFF, 1'b1, 1'b1, 32'hFFFFFFFF));
    drain();
    set_regs(32'hFFFFFFFF, 16'd65535, 16'd63487);
    send(mk(1'b1, hosts_a[5], hosts_p[5], 32'h0, 16'd1, 1'b1, 1'b0, 32'd5));
    send(mk(1'b1, 32'h0, 16'd1, 32'hFFFFFFFF, 16'd63487, 1'b0, 1'b0, 32'd6));
    send(mk(1'b0, 32'h0, 16'd1, 32'hFFFFFFFF, 16'd65535, 1'b0, 1'b0, 32'd7));
    drain();

    // random phases, each with its own registers and idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_regs(32'h0, 16'd0, 16'd1024);
        1: set_regs(32'hFFFFFFFF, 16'd65535, 16'd63487);
        2: set_regs($urandom, 16'd30, 16'd10000);
        default: set_regs($urandom, 16'($urandom_range(1, 60)),
                          16'($urandom_range(1024, 63487)));
      endcase
      // one phase runs time across the 32-bit wrap
      if (ph == 2) secs = 32'hFFFFFF00;
      idle_pct = (ph == 1) ? 69 : (ph == 3) ? 22 : 0;
      stall_pct = (ph == 2) ? 69 : (ph == 3) ? 22 : 0;
      repeat (68) send(rand_req());
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;
    repeat (50) @(posedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: nat_port_translation_table.f
design/nptt_pkg.sv
design/nptt_ctrl.sv
design/nptt_dp.sv
design/nat_port_translation_table.sv
bench/nptt_checker.sv
bench/tb_nat_port_translation_table.sv
